// File: src/ptate_pkg.sv
`default_nettype none
package ptate_pkg;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_last;
  } byte_out_t;

  // decimal digits of one channel, lead is the index of the first digit sent
  typedef struct packed {
    logic [3:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
    logic [1:0] lead;
  } dec_t;

  typedef struct packed {
    logic start;
    logic change;
    logic last;
    dec_t red;
    dec_t green;
    dec_t blue;
  } cmd_t;

  typedef enum logic [3:0] {
    PH_PREFIX,
    PH_LEAD,
    PH_RED,
    PH_SEMI1,
    PH_GREEN,
    PH_SEMI2,
    PH_BLUE,
    PH_MARK,
    PH_SPACE,
    PH_RESET
  } phase_t;

  localparam int PrefixLen = 10;
  localparam int LeadLen   = 7;
  localparam int ResetLen  = 3;

  localparam logic [7:0] ESC_CHAR   = 8'h1B;
  localparam logic [7:0] SEMI_CHAR  = 8'h3B;
  localparam logic [7:0] MARK_CHAR  = 8'h6D;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;

  localparam logic [7:0] PREFIX_SEQ [PrefixLen] = '{
    ESC_CHAR, 8'h5B, 8'h34, 8'h38, 8'h3B, 8'h32, 8'h3B, 8'h3B, 8'h3B, 8'h6D
  };
  localparam logic [7:0] LEAD_SEQ [LeadLen] = '{
    ESC_CHAR, 8'h5B, 8'h34, 8'h38, 8'h3B, 8'h32, 8'h3B
  };
  localparam logic [7:0] RESET_SEQ [ResetLen] = '{ESC_CHAR, 8'h5B, 8'h6D};

  function automatic dec_t to_decimal(input logic [7:0] v);
    dec_t        d;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [6:0]  tens_part;
    if (v >= 8'd200) begin
      d.hun = 4'd2;
      rem   = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      d.hun = 4'd1;
      rem   = 7'(v - 8'd100);
    end else begin
      d.hun = 4'd0;
      rem   = v[6:0];
    end
    // rem / 10 by reciprocal, exact below 100
    prod      = 15'(rem) * 15'd205;
    d.ten     = prod[14:11];
    tens_part = 7'({3'd0, d.ten} * 7'd10);
    d.one     = 4'(rem - tens_part);
    if (d.hun != 4'd0) d.lead = 2'd0;
    else if (d.ten != 4'd0) d.lead = 2'd1;
    else d.lead = 2'd2;
    return d;
  endfunction

endpackage
`default_nettype wire

// File: src/ptate_front.sv
`default_nettype none
module ptate_front (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic               in_ready,
  input  ptate_pkg::pix_in_t in_data,
  input  wire                logic q_full,
  output logic               push,
  output ptate_pkg::cmd_t    push_cmd
);

  logic [31:0] prev_r, prev_nxt;
  logic        started_r, started_nxt;
  logic [31:0] word;
  logic        change;

  assign word     = {in_data.alpha, in_data.red, in_data.green, in_data.blue};
  assign change   = !started_r || (word != prev_r);
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_cmd.start  = !started_r;
    push_cmd.change = change;
    push_cmd.last   = in_data.frame_end;
    push_cmd.red    = ptate_pkg::to_decimal(in_data.red);
    push_cmd.green  = ptate_pkg::to_decimal(in_data.green);
    push_cmd.blue   = ptate_pkg::to_decimal(in_data.blue);
  end

  always_comb begin
    prev_nxt    = prev_r;
    started_nxt = started_r;
    if (push) begin
      if (change) prev_nxt = word;
      started_nxt = !in_data.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      started_r <= 1'b0;
    end else begin
      prev_r    <= prev_nxt;
      started_r <= started_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/ptate_queue.sv
`default_nettype none
module ptate_queue (
  input  wire             logic clk,
  input  wire             logic rst_n,
  input  wire             logic push,
  input  ptate_pkg::cmd_t push_cmd,
  input  wire             logic pop,
  output logic            full,
  output logic            head_valid,
  output ptate_pkg::cmd_t head
);

  ptate_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/ptate_back.sv
`default_nettype none
module ptate_back (
  input  wire                  logic clk,
  input  wire                  logic rst_n,
  input  wire                  logic head_valid,
  input  ptate_pkg::cmd_t      head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  logic out_ready,
  output ptate_pkg::byte_out_t out_data
);

  ptate_pkg::phase_t phase_r, phase_nxt, cur_phase;
  logic [3:0]        idx_r, idx_nxt, cur_idx;
  logic              fresh_r, fresh_nxt;
  logic              out_valid_r, out_valid_nxt;
  ptate_pkg::byte_out_t out_data_r, out_data_nxt;
  logic              emit;
  logic              done;
  logic [7:0]        cur_byte;

  function automatic logic [7:0] digit_char(input ptate_pkg::dec_t d, input logic [1:0] i);
    logic [3:0] v;
    case (i)
      2'd0:    v = d.hun;
      2'd1:    v = d.ten;
      default: v = d.one;
    endcase
    return ptate_pkg::ZERO_CHAR + {4'd0, v};
  endfunction

  // next byte's position, the first for a new head word
  always_comb begin
    if (fresh_r) begin
      if (head.start) cur_phase = ptate_pkg::PH_PREFIX;
      else if (head.change) cur_phase = ptate_pkg::PH_LEAD;
      else cur_phase = ptate_pkg::PH_SPACE;
      cur_idx = 4'd0;
    end else begin
      cur_phase = phase_r;
      cur_idx   = idx_r;
    end
  end

  assign emit = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    cur_byte  = ptate_pkg::SPACE_CHAR;
    done      = 1'b0;
    phase_nxt = cur_phase;
    idx_nxt   = cur_idx + 4'd1;
    case (cur_phase)
      ptate_pkg::PH_PREFIX: begin
        cur_byte = ptate_pkg::PREFIX_SEQ[cur_idx];
        if (cur_idx == 4'(ptate_pkg::PrefixLen - 1)) begin
          phase_nxt = ptate_pkg::PH_LEAD;
          idx_nxt   = 4'd0;
        end
      end
      ptate_pkg::PH_LEAD: begin
        cur_byte = ptate_pkg::LEAD_SEQ[cur_idx[2:0]];
        if (cur_idx == 4'(ptate_pkg::LeadLen - 1)) begin
          phase_nxt = ptate_pkg::PH_RED;
          idx_nxt   = {2'd0, head.red.lead};
        end
      end
      ptate_pkg::PH_RED: begin
        cur_byte = digit_char(head.red, cur_idx[1:0]);
        if (cur_idx[1:0] == 2'd2) phase_nxt = ptate_pkg::PH_SEMI1;
      end
      ptate_pkg::PH_SEMI1: begin
        cur_byte  = ptate_pkg::SEMI_CHAR;
        phase_nxt = ptate_pkg::PH_GREEN;
        idx_nxt   = {2'd0, head.green.lead};
      end
      ptate_pkg::PH_GREEN: begin
        cur_byte = digit_char(head.green, cur_idx[1:0]);
        if (cur_idx[1:0] == 2'd2) phase_nxt = ptate_pkg::PH_SEMI2;
      end
      ptate_pkg::PH_SEMI2: begin
        cur_byte  = ptate_pkg::SEMI_CHAR;
        phase_nxt = ptate_pkg::PH_BLUE;
        idx_nxt   = {2'd0, head.blue.lead};
      end
      ptate_pkg::PH_BLUE: begin
        cur_byte = digit_char(head.blue, cur_idx[1:0]);
        if (cur_idx[1:0] == 2'd2) phase_nxt = ptate_pkg::PH_MARK;
      end
      ptate_pkg::PH_MARK: begin
        cur_byte  = ptate_pkg::MARK_CHAR;
        phase_nxt = ptate_pkg::PH_SPACE;
      end
      ptate_pkg::PH_SPACE: begin
        cur_byte  = ptate_pkg::SPACE_CHAR;
        phase_nxt = ptate_pkg::PH_RESET;
        idx_nxt   = 4'd0;
        done      = !head.last;
      end
      ptate_pkg::PH_RESET: begin
        cur_byte = ptate_pkg::RESET_SEQ[cur_idx[1:0]];
        done     = (cur_idx[1:0] == 2'(ptate_pkg::ResetLen - 1));
      end
      default: begin
        cur_byte = ptate_pkg::SPACE_CHAR;
        done     = 1'b1;
      end
    endcase
  end

  assign pop = emit && done;

  always_comb begin
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.out_byte   = cur_byte;
      out_data_nxt.run_last   = done;
      out_data_nxt.frame_last = done && (cur_phase == ptate_pkg::PH_RESET);
      fresh_nxt               = done;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && !done) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: src/pixel_to_ansi_truecolor_encoder.sv
// an accepted pixel is written into the queue, and its first byte is then registered in the output register
// throughput: one byte per cycle while out_ready is high and a pixel is queued; a pixel makes 1 byte
// unchanged, up to 20 on a colour change, 3 more on a frame end, 33 at most at frame start, all issued by
// the byte sequencer; a two-word queue between classifier and sequencer absorbs output stalls
// synchronous active-low reset clears the queue, the output valid flag and the
// previous colour, and the next pixel starts a frame
`default_nettype none
module pixel_to_ansi_truecolor_encoder (
  input  wire                  logic clk,
  input  wire                  logic rst_n,
  input  wire                  logic in_valid,
  output logic                 in_ready,
  input  ptate_pkg::pix_in_t   in_data,
  output logic                 out_valid,
  input  wire                  logic out_ready,
  output ptate_pkg::byte_out_t out_data
);

  logic            q_full;
  logic            push;
  ptate_pkg::cmd_t push_cmd;
  logic            pop;
  logic            head_valid;
  ptate_pkg::cmd_t head;

  ptate_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ptate_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  ptate_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// File: tb/sv/pixel_to_ansi_truecolor_encoder_test.sv
`default_nettype none
// keeps the terminal bytes each accepted pixel should produce, oldest first
class ansi_stream_board;
  ptate_pkg::byte_out_t expected_bytes[$];
  logic [31:0] last_colour = '0;
  logic        in_frame    = 1'b0;
  int          mismatches  = 0;
  int          bytes_seen  = 0;
  int          frames_done = 0;
  int          colour_sets = 0;

  task report(string msg);
    mismatches++;
    $display("error: %s", msg);
  endtask

  function void push_byte(logic [7:0] b);
    ptate_pkg::byte_out_t e;
    e.out_byte   = b;
    e.run_last   = 1'b0;
    e.frame_last = 1'b0;
    expected_bytes.push_back(e);
  endfunction

  function void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  // unpadded decimal, a zero tens digit is kept once hundreds are shown
  function void push_decimal(logic [7:0] v);
    int h;
    int t;
    int o;
    h = v / 100;
    t = (v / 10) % 10;
    o = v % 10;
    if (h != 0) push_byte(8'(h + 48));
    if (h != 0 || t != 0) push_byte(8'(t + 48));
    push_byte(8'(o + 48));
  endfunction

  function void note_pixel(ptate_pkg::pix_in_t p);
    logic [31:0]          word;
    logic                 change;
    ptate_pkg::byte_out_t tail;
    word   = {p.alpha, p.red, p.green, p.blue};
    change = (word != last_colour);
    if (!in_frame) begin
      push_text("\033[48;2;;;m");
      in_frame = 1'b1;
      change   = 1'b1;
    end
    if (change) begin
      push_text("\033[48;2;");
      push_decimal(p.red);
      push_text(";");
      push_decimal(p.green);
      push_text(";");
      push_decimal(p.blue);
      push_text("m");
      last_colour = word;
      colour_sets++;
    end
    push_text(" ");
    if (p.frame_end) begin
      push_text("\033[m");
      in_frame = 1'b0;
      frames_done++;
    end
    tail = expected_bytes.pop_back();
    tail.run_last = 1'b1;
    if (p.frame_end) tail.frame_last = 1'b1;
    expected_bytes.push_back(tail);
  endfunction

  task check_byte(ptate_pkg::byte_out_t got);
    ptate_pkg::byte_out_t want;
    bytes_seen++;
    if (expected_bytes.size() == 0) begin
      report($sformatf("byte %0d: unexpected word %02h", bytes_seen, got.out_byte));
      return;
    end
    want = expected_bytes.pop_front();
    if (got.out_byte !== want.out_byte)
      report($sformatf("byte %0d: out_byte %02h, want %02h",
                       bytes_seen, got.out_byte, want.out_byte));
    if (got.run_last !== want.run_last)
      report($sformatf("byte %0d: run_last %b, want %b",
                       bytes_seen, got.run_last, want.run_last));
    if (got.frame_last !== want.frame_last)
      report($sformatf("byte %0d: frame_last %b, want %b",
                       bytes_seen, got.frame_last, want.frame_last));
  endtask
endclass

module pixel_to_ansi_truecolor_encoder_test;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  ptate_pkg::pix_in_t   in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  ptate_pkg::byte_out_t out_data;

  ansi_stream_board board;

  int pixels_sent = 0;
  int burst_left  = 0;
  int hold_asks   = 0;
  int hold_taken  = 0;
  int hold_left   = 0;
  int pattern_age = 0;
  logic [15:0] ready_pattern = 16'hFFFF;

  pixel_to_ansi_truecolor_encoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  initial begin
    #10000000;
    $display("pixel_to_ansi_truecolor_encoder: mismatch");
    $finish;
  end

  // receiver: rotating ready pattern, renewed now and then, with long hold-offs on request
  always @(posedge clk) begin
    if (out_valid && out_ready) board.check_byte(out_data);
    if (hold_asks != hold_taken) begin
      hold_taken = hold_asks;
      hold_left  = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern = 16'hFFFF;
          1:       ready_pattern = 16'($urandom) | 16'($urandom);
          default: ready_pattern = 16'($urandom) | 16'h0001;
        endcase
        pattern_age = $urandom_range(16, 96);
      end
      pattern_age = pattern_age - 1;
      out_ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  function automatic ptate_pkg::pix_in_t pixel_of(logic [7:0] a, logic [7:0] r,
                                                  logic [7:0] g, logic [7:0] b, logic fe);
    ptate_pkg::pix_in_t p;
    p.alpha     = a;
    p.red       = r;
    p.green     = g;
    p.blue      = b;
    p.frame_end = fe;
    return p;
  endfunction

  // spread channel values over one, two and three decimal digits
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 9));
      1:       return 8'($urandom_range(10, 99));
      2:       return 8'($urandom_range(100, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input ptate_pkg::pix_in_t p);
    int gap;
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pixel(p);
    pixels_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      case ($urandom_range(0, 5))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(10, 30);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.expected_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    ptate_pkg::pix_in_t directed[$];
    ptate_pkg::pix_in_t px;
    int                 frame_len;
    board = new;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first pixel equal to the reset colour still gets a colour sequence
    directed.push_back(pixel_of(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    directed.push_back(pixel_of(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    directed.push_back(pixel_of(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0));
    directed.push_back(pixel_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    directed.push_back(pixel_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    directed.push_back(pixel_of(8'h00, 8'd100, 8'd10, 8'd9, 1'b0));
    directed.push_back(pixel_of(8'h00, 8'd200, 8'd199, 8'd99, 1'b0));
    directed.push_back(pixel_of(8'h00, 8'd1, 8'd20, 8'd255, 1'b0));
    directed.push_back(pixel_of(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0));
    directed.push_back(pixel_of(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0));
    directed.push_back(pixel_of(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1));
    // single-pixel frames, the first repeating the colour just used
    directed.push_back(pixel_of(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1));
    directed.push_back(pixel_of(8'h07, 8'd1, 8'd2, 8'd3, 1'b1));
    directed.push_back(pixel_of(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
    directed.push_back(pixel_of(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    directed.push_back(pixel_of(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    directed.push_back(pixel_of(8'h80, 8'd128, 8'd64, 8'd32, 1'b0));
    directed.push_back(pixel_of(8'h01, 8'd250, 8'd5, 8'd50, 1'b0));
    directed.push_back(pixel_of(8'h01, 8'd250, 8'd5, 8'd50, 1'b1));
    foreach (directed[i]) send_pixel(directed[i]);
    drain();

    px = pixel_of(8'($urandom), pick_channel(), pick_channel(), pick_channel(), 1'b0);
    while (pixels_sent < 420) begin
      if ($urandom_range(0, 9) == 0) frame_len = $urandom_range(13, 40);
      else frame_len = $urandom_range(1, 12);
      for (int k = 0; k < frame_len; k++) begin
        // runs of one colour, alpha-only changes, red-only changes and fresh colours
        case ($urandom_range(0, 7))
          0, 1, 2: ;
          3:       px.alpha = 8'($urandom);
          4:       px.red   = pick_channel();
          default: begin
            px.alpha = 8'($urandom);
            px.red   = pick_channel();
            px.green = pick_channel();
            px.blue  = pick_channel();
          end
        endcase
        px.frame_end = (k == frame_len - 1);
        // occasional early frame end
        if ($urandom_range(0, 29) == 0) px.frame_end = 1'b1;
        send_pixel(px);
        if (pixels_sent == 120 || pixels_sent == 300) hold_asks <= hold_asks + 1;
        if (pixels_sent == 220) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d pixels over %0d frames with %0d colour sequences",
             pixels_sent, board.frames_done, board.colour_sets);
    $display("checked %0d output words, %0d mismatches", board.bytes_seen, board.mismatches);
    if (board.mismatches == 0 && board.expected_bytes.size() == 0) begin
      $display("pixel_to_ansi_truecolor_encoder: match");
    end else begin
      $display("pixel_to_ansi_truecolor_encoder: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
